@@ rtl/polar_rect_converter_top_defines.svh @@
// assertion macros shared by the converter modules
`ifndef POLAR_RECT_CONVERTER_TOP_DEFINES_SVH
`define POLAR_RECT_CONVERTER_TOP_DEFINES_SVH

// consequent checked in the same cycle
`define PRC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define PRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/prc_pkg.sv @@
package prc_pkg;

    localparam int ITERATIONS = 16;
    localparam int STAGE_W    = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;
    localparam int TAB_LEN    = 24;
    localparam int TAB_W      = 5;
    localparam int DW         = 35;
    localparam int ZW         = 34;
    localparam int FRAC       = 16;

    localparam logic signed [30:0] GAIN_Q30    = 31'sd652032874;
    localparam logic [29:0]        GAIN_Q30_U  = 30'd652032874;
    localparam logic [31:0]        HALF_TURN   = 32'h8000_0000;
    localparam logic [1:0]         Q_SECOND    = 2'b01;
    localparam logic [1:0]         Q_THIRD     = 2'b10;
    localparam logic               MODE_TO_RECT  = 1'b0;
    localparam logic               MODE_TO_POLAR = 1'b1;
    localparam logic [16:0]        R_MAX       = 17'd46341;

    localparam logic [31:0] ATAN_TURNS [TAB_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic                 mode;
        logic                 zero;
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [ZW-1:0] z;
    } prc_item_t;

    function automatic logic [31:0] atan_at(input logic [TAB_W-1:0] idx);
        logic [31:0] val;
        val = 32'd0;
        if (int'(idx) < TAB_LEN)
        begin
            val = ATAN_TURNS[idx];
        end
        return val;
    endfunction

endpackage

@@ rtl/prc_pre.sv @@
module prc_pre (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                mode,
    input  logic signed [15:0]  first_in,
    input  logic signed [15:0]  second_in,
    output prc_pkg::prc_item_t  item,
    output logic                item_valid,
    input  logic                item_ready
);
    import prc_pkg::*;

    prc_item_t            item_reg;
    prc_item_t            item_next;
    logic                 valid_reg;
    logic signed [16:0]   r_s;
    logic signed [47:0]   prod;
    logic signed [47:0]   prod_rnd;
    logic [31:0]          zu;
    logic [1:0]           quad;
    logic signed [DW-1:0] xs;
    logic signed [DW-1:0] ys;

    assign in_ready = !valid_reg || item_ready;

    always_comb
    begin
        quad      = second_in[15:14];
        zu        = {second_in, 16'h0000};
        r_s       = 17'(first_in);
        if (quad == Q_SECOND || quad == Q_THIRD)
        begin
            r_s = -r_s;
            zu  = zu ^ HALF_TURN;
        end
        prod      = 48'(r_s) * 48'(GAIN_Q30);
        prod_rnd  = (prod + 48'sd8192) >>> (30 - FRAC);
        xs        = DW'(first_in) <<< FRAC;
        ys        = DW'(second_in) <<< FRAC;
        item_next = '0;
        item_next.mode = mode;
        if (mode == MODE_TO_RECT)
        begin
            item_next.x = DW'(prod_rnd);
            item_next.y = '0;
            item_next.z = ZW'($signed(zu));
        end
        else
        begin
            item_next.zero = (first_in == 16'sd0) && (second_in == 16'sd0);
            if (first_in < 0)
            begin
                item_next.x = -xs;
                item_next.y = -ys;
                item_next.z = ZW'(HALF_TURN);
            end
            else
            begin
                item_next.x = xs;
                item_next.y = ys;
                item_next.z = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

@@ rtl/prc_cell.sv @@
module prc_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [prc_pkg::STAGE_W-1:0] stage,
    input  prc_pkg::prc_item_t        in_item,
    input  logic                      in_valid,
    output logic                      in_ready,
    output prc_pkg::prc_item_t        out_item,
    output logic                      out_valid,
    input  logic                      out_ready
);
    import prc_pkg::*;

    prc_item_t            data_reg;
    prc_item_t            data_next;
    logic                 valid_reg;
    logic signed [DW-1:0] half;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [ZW-1:0] da;
    logic                 fwd;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        half = '0;
        if (stage != '0)
        begin
            half = DW'(1) <<< (stage - STAGE_W'(1));
        end
        dx  = (in_item.y + half) >>> stage;
        dy  = (in_item.x + half) >>> stage;
        da  = ZW'(atan_at(TAB_W'(stage)));
        fwd = (in_item.mode == MODE_TO_RECT) ? !in_item.z[ZW-1] : in_item.y[DW-1];
        data_next = in_item;
        if (fwd)
        begin
            data_next.x = in_item.x - dx;
            data_next.y = in_item.y + dy;
            data_next.z = in_item.z - da;
        end
        else
        begin
            data_next.x = in_item.x + dx;
            data_next.y = in_item.y - dy;
            data_next.z = in_item.z + da;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_item  = data_reg;
    assign out_valid = valid_reg;

endmodule

@@ rtl/prc_post.sv @@
`include "polar_rect_converter_top_defines.svh"

module prc_post (
    input  logic                clk,
    input  logic                rst_n,
    input  prc_pkg::prc_item_t  item,
    input  logic                item_valid,
    output logic                item_ready,
    output logic signed [16:0]  first_out,
    output logic signed [15:0]  second_out,
    output logic                mode_out,
    output logic                out_valid,
    input  logic                out_stall
);
    import prc_pkg::*;

    logic signed [16:0]         first_reg;
    logic signed [16:0]         first_next;
    logic signed [15:0]         second_reg;
    logic signed [15:0]         second_next;
    logic                       mode_reg;
    logic                       valid_reg;
    logic signed [DW-1:0]       xr;
    logic signed [DW-1:0]       yr;
    logic [62:0]                rprod;
    logic [62:0]                rrnd;
    logic [31:0]                ang;

    assign item_ready = !valid_reg || !out_stall;

    function automatic logic signed [16:0] sat16(input logic signed [DW-1:0] v);
        logic signed [16:0] res;
        if (v > DW'(32767))
        begin
            res = 17'sd32767;
        end
        else if (v < -DW'(32768))
        begin
            res = -17'sd32768;
        end
        else
        begin
            res = 17'(v);
        end
        return res;
    endfunction

    always_comb
    begin
        xr    = (item.x + DW'(32768)) >>> FRAC;
        yr    = (item.y + DW'(32768)) >>> FRAC;
        rprod = 63'(item.x[32:0]) * 63'(GAIN_Q30_U);
        rrnd  = (rprod + (63'(1) << (30 + FRAC - 1))) >> (30 + FRAC);
        ang   = (item.z[31:0] + 32'h0000_8000) >> 16;
        if (item.mode == MODE_TO_RECT)
        begin
            first_next  = sat16(xr);
            second_next = 16'(sat16(yr));
        end
        else if (item.zero || item.x[DW-1])
        begin
            first_next  = '0;
            second_next = item.zero ? 16'sd0 : $signed(ang[15:0]);
        end
        else
        begin
            if (rrnd > 63'(R_MAX))
            begin
                first_next = $signed(R_MAX);
            end
            else
            begin
                first_next = $signed(rrnd[16:0]);
            end
            second_next = $signed(ang[15:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            first_reg  <= first_next;
            second_reg <= second_next;
            mode_reg   <= item.mode;
        end
    end

    assign first_out  = first_reg;
    assign second_out = second_reg;
    assign mode_out   = mode_reg;
    assign out_valid  = valid_reg;

    `PRC_ASSERT_NEXT(a_origin_zero, item_valid && item_ready && item.mode && item.zero,
        first_reg == 17'sd0 && second_reg == 16'sd0, "origin item gave nonzero result")

endmodule

@@ rtl/polar_rect_converter_top.sv @@
// polar / rectangular coordinate converter, rounded cordic pipeline
// input channel: in_valid / in_stall carrying mode, first_in, second_in
//   mode 0: first_in radius, second_in binary angle (65536 per turn)
//   mode 1: first_in x, second_in y
// output channel: out_valid / out_stall carrying first_out, second_out, mode_out
//   mode 0: saturated x and y; mode 1: radius (0..46341) and atan2 angle
// one result item per input item, in order
// pipeline: one pre-rotation stage (gain multiply), ITERATIONS cordic cells,
//   one output stage (rounding, radius multiply)
// throughput: one item per cycle while out_stall is low, set by one cordic cell per rotation step
// every stage holds its item when the next one is full, so bubbles close up
//   and in_stall rises only when every stage holds an item behind a stalled
//   output
// reset clears all stage valid bits; no items are held after reset
`include "polar_rect_converter_top_defines.svh"

module polar_rect_converter_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                mode,
    input  logic signed [15:0]  first_in,
    input  logic signed [15:0]  second_in,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [16:0]  first_out,
    output logic signed [15:0]  second_out,
    output logic                mode_out
);
    import prc_pkg::*;

    prc_item_t chain_item  [ITERATIONS+1];
    logic      chain_valid [ITERATIONS+1];
    logic      chain_ready [ITERATIONS+1];
    logic      pre_ready;

    assign in_stall = !pre_ready;

    prc_pre u_pre (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (pre_ready),
        .mode       (mode),
        .first_in   (first_in),
        .second_in  (second_in),
        .item       (chain_item[0]),
        .item_valid (chain_valid[0]),
        .item_ready (chain_ready[0])
    );

    for (genvar g = 0; g < ITERATIONS; g++)
    begin : g_cell
        prc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage     (STAGE_W'(g)),
            .in_item   (chain_item[g]),
            .in_valid  (chain_valid[g]),
            .in_ready  (chain_ready[g]),
            .out_item  (chain_item[g+1]),
            .out_valid (chain_valid[g+1]),
            .out_ready (chain_ready[g+1])
        );
    end

    prc_post u_post (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (chain_item[ITERATIONS]),
        .item_valid (chain_valid[ITERATIONS]),
        .item_ready (chain_ready[ITERATIONS]),
        .first_out  (first_out),
        .second_out (second_out),
        .mode_out   (mode_out),
        .out_valid  (out_valid),
        .out_stall  (out_stall)
    );

    `PRC_ASSERT_NOW(a_stall_backed, in_stall, out_valid && out_stall,
        "input stalled without a blocked output item")
    `PRC_ASSERT_NOW(a_radius_range, out_valid && mode_out,
        first_out >= 17'sd0 && first_out <= 17'sd46341, "radius out of range")
    `PRC_ASSERT_NOW(a_rect_sat, out_valid && !mode_out,
        first_out >= -17'sd32768 && first_out <= 17'sd32767, "x not saturated")

endmodule
